// ===== rtl/core/srsd_pkg.sv =====
`default_nettype none

package srsd_pkg;

    localparam int MAX_DIM      = 1024;
    localparam int PALETTE_SIZE = 256;

    localparam int PAL_AW   = $clog2(PALETTE_SIZE);
    localparam int COORD_W  = 11;
    localparam int SPAN_W   = 10;
    localparam int CFG_IW   = 3;
    localparam int CFG_DW   = 11;

    localparam logic [COORD_W-1:0] COORD_MAX = {COORD_W{1'b1}};
    localparam logic [COORD_W-1:0] DIM_CAP   = COORD_W'(MAX_DIM);
    localparam logic [SPAN_W-1:0]  XY_MAX    = SPAN_W'(MAX_DIM - 1);

    // register indexes of the configuration port
    localparam logic [CFG_IW-1:0] REG_IMAGE_WIDTH  = 3'd0;
    localparam logic [CFG_IW-1:0] REG_IMAGE_HEIGHT = 3'd1;
    localparam logic [CFG_IW-1:0] REG_FIRST_COLUMN = 3'd2;
    localparam logic [CFG_IW-1:0] REG_FIRST_ROW    = 3'd3;
    localparam logic [CFG_IW-1:0] REG_LAST_COLUMN  = 3'd4;
    localparam logic [CFG_IW-1:0] REG_LAST_ROW     = 3'd5;
    localparam logic [CFG_IW-1:0] REG_DEBUG_MODE   = 3'd6;

    localparam logic OP_SHAPE   = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    typedef enum logic [1:0] {
        PH_CMD,
        PH_SKIP,
        PH_RUN,
        PH_LIT
    } phase_t;

    typedef struct packed {
        logic [SPAN_W-1:0]  span_x;
        logic [SPAN_W-1:0]  span_y;
        logic [COORD_W-1:0] span_length;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [7:0]         alpha;
        logic               last;
        logic               header_error;
        logic               use_pal;
    } span_t;

    // config write request from the port to the decoder
    typedef struct packed {
        logic              we;
        logic [CFG_IW-1:0] index;
        logic [CFG_DW-1:0] data;
    } cfg_wr_t;

endpackage

`default_nettype wire

// ===== rtl/core/srsd_if.sv =====
`default_nettype none

interface srsd_item_if;
    logic       valid;
    logic       ready;
    logic       op;
    logic [7:0] code_byte;
    logic [7:0] pal_index;
    logic [7:0] pal_red;
    logic [7:0] pal_green;
    logic [7:0] pal_blue;

    modport source (
        output valid, op, code_byte, pal_index, pal_red, pal_green, pal_blue,
        input  ready
    );
    modport sink (
        input  valid, op, code_byte, pal_index, pal_red, pal_green, pal_blue,
        output ready
    );
endinterface

interface srsd_span_if;
    logic        valid;
    logic        ready;
    logic [9:0]  span_x;
    logic [9:0]  span_y;
    logic [10:0] span_length;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last;
    logic        header_error;

    modport source (
        output valid, span_x, span_y, span_length, red, green, blue, alpha,
               last, header_error,
        input  ready
    );
    modport sink (
        input  valid, span_x, span_y, span_length, red, green, blue, alpha,
               last, header_error,
        output ready
    );
endinterface

interface srsd_cfg_if;
    logic        valid;
    logic        ready;
    logic [2:0]  index;
    logic [10:0] data;

    modport source (
        output valid, index, data,
        input  ready
    );
    modport sink (
        input  valid, index, data,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/srsd_palette.sv =====
`default_nettype none

module srsd_palette
    import srsd_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [PAL_AW-1:0] waddr,
    input  wire logic [23:0]       wdata,
    input  wire logic              re,
    input  wire logic [PAL_AW-1:0] raddr,
    output logic      [23:0]       rdata
);

    logic [23:0] mem [PALETTE_SIZE];
    logic [23:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // read data only moves on a read, so a stalled span keeps its colour
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

// ===== rtl/core/srsd_decode.sv =====
`default_nettype none

module srsd_decode
    import srsd_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire cfg_wr_t   cfg_wr,
    input  wire logic      shape_we,
    input  wire logic [7:0] code_byte,
    output logic           res_valid,
    output span_t          res
);

    logic [COORD_W-1:0] image_width_reg,  image_width_next;
    logic [COORD_W-1:0] image_height_reg, image_height_next;
    logic [COORD_W-1:0] first_column_reg, first_column_next;
    logic [COORD_W-1:0] first_row_reg,    first_row_next;
    logic [COORD_W-1:0] last_column_reg,  last_column_next;
    logic [COORD_W-1:0] last_row_reg,     last_row_next;
    logic               debug_mode_reg,   debug_mode_next;

    phase_t             phase_reg,    phase_next;
    logic [6:0]         run_left_reg, run_left_next;
    logic [COORD_W-1:0] cur_x_reg,    cur_x_next;
    logic [COORD_W-1:0] cur_y_reg,    cur_y_next;
    logic               done_reg,     done_next;

    logic               cfg_hit;
    logic               hdr_bad;
    logic [COORD_W-1:0] wcap, hcap, room, n, len, x_add, ny;
    logic [COORD_W:0]   x_sum;
    logic               in_img, fin;
    logic [7:0]         dbg;
    logic [6:0]         run_dec;

    always_comb
    begin
        image_width_next  = image_width_reg;
        image_height_next = image_height_reg;
        first_column_next = first_column_reg;
        first_row_next    = first_row_reg;
        last_column_next  = last_column_reg;
        last_row_next     = last_row_reg;
        debug_mode_next   = debug_mode_reg;
        cfg_hit           = 1'b0;
        if (cfg_wr.we)
        begin
            cfg_hit = 1'b1;
            case (cfg_wr.index)
                REG_IMAGE_WIDTH:  image_width_next  = cfg_wr.data;
                REG_IMAGE_HEIGHT: image_height_next = cfg_wr.data;
                REG_FIRST_COLUMN: first_column_next = cfg_wr.data;
                REG_FIRST_ROW:    first_row_next    = cfg_wr.data;
                REG_LAST_COLUMN:  last_column_next  = cfg_wr.data;
                REG_LAST_ROW:     last_row_next     = cfg_wr.data;
                REG_DEBUG_MODE:   debug_mode_next   = cfg_wr.data[0];
                default:          cfg_hit           = 1'b0;
            endcase
        end
    end

    always_comb
    begin
        hdr_bad = (first_column_reg > image_width_reg) || (last_column_reg > image_width_reg)
               || (first_row_reg > image_height_reg) || (last_row_reg > image_height_reg);
        wcap    = (image_width_reg > DIM_CAP) ? DIM_CAP : image_width_reg;
        hcap    = (image_height_reg > DIM_CAP) ? DIM_CAP : image_height_reg;
        in_img  = (cur_y_reg < hcap) && (cur_x_reg < wcap);
        room    = wcap - cur_x_reg;
        dbg     = {8{debug_mode_reg}};
        run_dec = run_left_reg - 7'd1;

        case (phase_reg)
            PH_CMD:  n = room;
            PH_SKIP: n = {3'b000, code_byte};
            PH_RUN:  n = {4'b0000, run_left_reg};
            PH_LIT:  n = 11'd1;
            default: n = 11'd0;
        endcase

        len   = in_img ? ((n < room) ? n : room) : '0;
        x_sum = {1'b0, cur_x_reg} + {1'b0, n};
        x_add = x_sum[COORD_W] ? COORD_MAX : x_sum[COORD_W-1:0];
        ny    = (cur_y_reg == COORD_MAX) ? COORD_MAX : cur_y_reg + 11'd1;
        fin   = (ny > image_height_reg) || (ny > last_row_reg);

        phase_next    = phase_reg;
        run_left_next = run_left_reg;
        cur_x_next    = cur_x_reg;
        cur_y_next    = cur_y_reg;
        done_next     = done_reg;
        res_valid     = 1'b0;

        res              = '0;
        res.span_x       = (cur_x_reg > {1'b0, XY_MAX}) ? XY_MAX : cur_x_reg[SPAN_W-1:0];
        res.span_y       = (cur_y_reg > {1'b0, XY_MAX}) ? XY_MAX : cur_y_reg[SPAN_W-1:0];
        res.span_length  = len;
        res.alpha        = 8'hFF;

        if (cfg_hit)
        begin
            phase_next    = PH_CMD;
            run_left_next = '0;
            cur_x_next    = first_column_next;
            cur_y_next    = first_row_next;
            done_next     = 1'b0;
        end
        else if (shape_we && !done_reg)
        begin
            if (hdr_bad)
            begin
                res_valid        = 1'b1;
                res              = '0;
                res.last         = 1'b1;
                res.header_error = 1'b1;
                done_next        = 1'b1;
            end
            else
            begin
                case (phase_reg)
                    PH_CMD:
                    begin
                        if (code_byte == 8'd0)
                        begin
                            // row end: rest of the row goes out transparent unless debug mode is on
                            res_valid  = 1'b1;
                            res.green  = dbg;
                            res.alpha  = dbg;
                            res.last   = fin;
                            cur_x_next = first_column_reg;
                            cur_y_next = ny;
                            done_next  = fin;
                        end
                        else if (code_byte == 8'd1)
                        begin
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            phase_next    = code_byte[0] ? PH_LIT : PH_RUN;
                            run_left_next = code_byte[7:1];
                        end
                    end
                    PH_SKIP:
                    begin
                        res_valid  = 1'b1;
                        res.red    = dbg;
                        res.green  = dbg;
                        res.alpha  = dbg;
                        cur_x_next = x_add;
                        phase_next = PH_CMD;
                    end
                    PH_RUN:
                    begin
                        res_valid     = 1'b1;
                        res.use_pal   = 1'b1;
                        cur_x_next    = x_add;
                        run_left_next = '0;
                        phase_next    = PH_CMD;
                    end
                    default:
                    begin
                        res_valid     = 1'b1;
                        res.use_pal   = 1'b1;
                        cur_x_next    = x_add;
                        run_left_next = run_dec;
                        if (run_dec == 7'd0)
                        begin
                            phase_next = PH_CMD;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_width_reg  <= 11'd1;
            image_height_reg <= 11'd1;
            first_column_reg <= '0;
            first_row_reg    <= '0;
            last_column_reg  <= '0;
            last_row_reg     <= '0;
            debug_mode_reg   <= 1'b0;
            phase_reg        <= PH_CMD;
            run_left_reg     <= '0;
            cur_x_reg        <= '0;
            cur_y_reg        <= '0;
            done_reg         <= 1'b0;
        end
        else
        begin
            image_width_reg  <= image_width_next;
            image_height_reg <= image_height_next;
            first_column_reg <= first_column_next;
            first_row_reg    <= first_row_next;
            last_column_reg  <= last_column_next;
            last_row_reg     <= last_row_next;
            debug_mode_reg   <= debug_mode_next;
            phase_reg        <= phase_next;
            run_left_reg     <= run_left_next;
            cur_x_reg        <= cur_x_next;
            cur_y_reg        <= cur_y_next;
            done_reg         <= done_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/sprite_rle_span_decoder_top.sv =====
`default_nettype none

// Run-length sprite span decoder. Takes one word per clock on the item channel
// while the output does not stall, either a shape byte or a palette write, with no
// gaps needed between them; each shape byte that closes a span gives one span word.
// The decode state (phase, run count, cursor) is updated in the cycle a byte is
// taken, and the 256-entry palette is a synchronous RAM read in that same cycle,
// so palette writes show up for any byte that follows them. An output register and
// one pipeline stage let input keep flowing while a finished span waits. Configure
// only while idle; every register write restarts decoding at the first row and
// column. Reading a palette entry that was never written gives an undefined colour.
module sprite_rle_span_decoder_top
    import srsd_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    srsd_item_if.sink   item,
    srsd_span_if.source span,
    srsd_cfg_if.sink    cfg
);

    logic        accept;
    logic        shape_we;
    logic        s2_move;
    logic        res_valid;
    span_t       res;
    cfg_wr_t     cfg_wr;
    logic [23:0] pal_rdata;
    span_t       s2_fill;

    logic        s2_valid_reg,  s2_valid_next;
    span_t       s2_reg;
    logic        out_valid_reg, out_valid_next;
    span_t       out_reg;

    assign cfg.ready    = 1'b1;
    assign cfg_wr.we    = cfg.valid;
    assign cfg_wr.index = cfg.index;
    assign cfg_wr.data  = cfg.data;

    assign s2_move    = !out_valid_reg || span.ready;
    assign item.ready = !s2_valid_reg || s2_move;
    assign accept     = item.valid && item.ready;
    assign shape_we   = accept && (item.op == OP_SHAPE);

    srsd_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr    (cfg_wr),
        .shape_we  (shape_we),
        .code_byte (item.code_byte),
        .res_valid (res_valid),
        .res       (res)
    );

    srsd_palette u_palette (
        .clk   (clk),
        .we    (accept && (item.op == OP_PALETTE)),
        .waddr (item.pal_index),
        .wdata ({item.pal_red, item.pal_green, item.pal_blue}),
        .re    (shape_we),
        .raddr (item.code_byte),
        .rdata (pal_rdata)
    );

    // palette colour joins the span on its way to the output register
    always_comb
    begin
        s2_fill = s2_reg;
        if (s2_reg.use_pal)
        begin
            s2_fill.red   = pal_rdata[23:16];
            s2_fill.green = pal_rdata[15:8];
            s2_fill.blue  = pal_rdata[7:0];
        end
    end

    always_comb
    begin
        s2_valid_next  = s2_valid_reg;
        out_valid_next = out_valid_reg;
        if (s2_move)
        begin
            out_valid_next = s2_valid_reg;
            s2_valid_next  = 1'b0;
        end
        if (accept)
        begin
            s2_valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            s2_valid_reg  <= s2_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s2_move)
        begin
            out_reg <= s2_fill;
        end
        if (accept && res_valid)
        begin
            s2_reg <= res;
        end
    end

    assign span.valid        = out_valid_reg;
    assign span.span_x       = out_reg.span_x;
    assign span.span_y       = out_reg.span_y;
    assign span.span_length  = out_reg.span_length;
    assign span.red          = out_reg.red;
    assign span.green        = out_reg.green;
    assign span.blue         = out_reg.blue;
    assign span.alpha        = out_reg.alpha;
    assign span.last         = out_reg.last;
    assign span.header_error = out_reg.header_error;

`ifndef SYNTHESIS
    // a held span in the pipeline stage must never be overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        s2_valid_reg && !s2_move |-> !accept)
        else $error("pipeline span overwritten");

    a_err_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.header_error |-> out_reg.last && out_reg.span_length == '0)
        else $error("header error span malformed");

    a_len_cap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> out_reg.span_length <= DIM_CAP)
        else $error("span length beyond image width cap");

    // palette colour spans are always opaque and never flagged as errors
    a_pal_opaque: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.use_pal |-> out_reg.alpha == 8'hFF && !out_reg.header_error)
        else $error("palette span not opaque");
`endif

endmodule

`default_nettype wire

// ===== sim/sprite_rle_span_decoder_top_tb.sv =====
`default_nettype none

module sprite_rle_span_decoder_top_tb;
    import srsd_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [7:0] CODE_ROW_END = 8'd0;
    localparam logic [7:0] CODE_SKIP    = 8'd1;
    localparam int         HOLD_CYCLES  = 400;
    localparam int         SETTLE       = 8;
    localparam int         DRAIN_LIMIT  = 20000;

    typedef struct packed {
        logic [9:0]  x;
        logic [9:0]  y;
        logic [10:0] len;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic        last;
        logic        herr;
    } span_word_t;

    class span_scoreboard;
        logic [10:0] img_w, img_h, col_first, row_first, col_last, row_last;
        bit          dbg;
        phase_t      phase;
        int          run_left, cur_x, cur_y;
        bit          done;
        logic [23:0] palette [256];
        span_word_t  spans_due [$];
        int          mismatches, spans_seen, header_errors, image_ends;

        function new();
            img_w = 11'd1;
            img_h = 11'd1;
            col_first = '0;
            row_first = '0;
            col_last = '0;
            row_last = '0;
            dbg = 1'b0;
            foreach (palette[i]) palette[i] = '0;
            restart();
        endfunction

        function void restart();
            phase = PH_CMD;
            run_left = 0;
            cur_x = col_first;
            cur_y = row_first;
            done = 1'b0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [10:0] v);
            case (idx)
                REG_IMAGE_WIDTH:  img_w = v;
                REG_IMAGE_HEIGHT: img_h = v;
                REG_FIRST_COLUMN: col_first = v;
                REG_FIRST_ROW:    row_first = v;
                REG_LAST_COLUMN:  col_last = v;
                REG_LAST_ROW:     row_last = v;
                REG_DEBUG_MODE:   dbg = v[0];
                default:          return;
            endcase
            restart();
        endfunction

        function bit header_bad();
            return col_first > img_w || col_last > img_w ||
                   row_first > img_h || row_last > img_h;
        endfunction

        // next shape byte will be looked up in the palette
        function bit wants_colour();
            return !done && !header_bad() && (phase == PH_RUN || phase == PH_LIT);
        endfunction

        function bit image_over();
            return done;
        endfunction

        function int pending();
            return spans_due.size();
        endfunction

        function int failures();
            return mismatches + spans_due.size();
        endfunction

        function int cap_dim(int v);
            return v > MAX_DIM ? MAX_DIM : v;
        endfunction

        function int sat_coord(int v);
            return v > 2047 ? 2047 : v;
        endfunction

        function int clip(int n);
            int w, h;
            w = cap_dim(img_w);
            h = cap_dim(img_h);
            if (cur_y >= h || cur_x >= w)
            begin
                return 0;
            end
            return n < w - cur_x ? n : w - cur_x;
        endfunction

        function void push_span(int n, logic [7:0] r, logic [7:0] g, logic [7:0] b,
                                logic [7:0] a, bit fin);
            span_word_t s;
            s.x = 10'(cur_x > MAX_DIM - 1 ? MAX_DIM - 1 : cur_x);
            s.y = 10'(cur_y > MAX_DIM - 1 ? MAX_DIM - 1 : cur_y);
            s.len = 11'(n);
            s.red = r;
            s.green = g;
            s.blue = b;
            s.alpha = a;
            s.last = fin;
            s.herr = 1'b0;
            if (fin)
            begin
                image_ends++;
            end
            spans_due.push_back(s);
        endfunction

        function void note_item(logic op, logic [7:0] code, logic [7:0] idx,
                                logic [7:0] r, logic [7:0] g, logic [7:0] b);
            span_word_t  err;
            logic [7:0]  dc;
            logic [23:0] c;
            int          w, ny;
            bit          fin;
            dc = dbg ? 8'hFF : 8'h00;
            if (op == OP_PALETTE)
            begin
                palette[idx] = {r, g, b};
                return;
            end
            if (done)
            begin
                return;
            end
            if (header_bad())
            begin
                err = '0;
                err.last = 1'b1;
                err.herr = 1'b1;
                spans_due.push_back(err);
                header_errors++;
                done = 1'b1;
                return;
            end
            case (phase)
                PH_CMD:
                begin
                    if (code == CODE_ROW_END)
                    begin
                        w = cap_dim(img_w);
                        ny = sat_coord(cur_y + 1);
                        fin = ny > img_h || ny > row_last;
                        push_span(clip(cur_x < w ? w - cur_x : 0), 8'h00, dc, 8'h00, dc, fin);
                        cur_x = col_first;
                        cur_y = ny;
                        done = fin;
                    end
                    else if (code == CODE_SKIP)
                    begin
                        phase = PH_SKIP;
                    end
                    else
                    begin
                        phase = code[0] ? PH_LIT : PH_RUN;
                        run_left = code[7:1];
                    end
                end
                PH_SKIP:
                begin
                    push_span(clip(code), dc, dc, 8'h00, dc, 1'b0);
                    cur_x = sat_coord(cur_x + code);
                    phase = PH_CMD;
                end
                PH_RUN:
                begin
                    c = palette[code];
                    push_span(clip(run_left), c[23:16], c[15:8], c[7:0], 8'hFF, 1'b0);
                    cur_x = sat_coord(cur_x + run_left);
                    run_left = 0;
                    phase = PH_CMD;
                end
                default:
                begin
                    c = palette[code];
                    push_span(clip(1), c[23:16], c[15:8], c[7:0], 8'hFF, 1'b0);
                    cur_x = sat_coord(cur_x + 1);
                    run_left = (run_left - 1) & 127;
                    if (run_left == 0)
                    begin
                        phase = PH_CMD;
                    end
                end
            endcase
        endfunction

        function string show(span_word_t s);
            return $sformatf("x=%0d y=%0d len=%0d rgba=%02h%02h%02h%02h last=%0b err=%0b",
                             s.x, s.y, s.len, s.red, s.green, s.blue, s.alpha,
                             s.last, s.herr);
        endfunction

        function void check_span(span_word_t got);
            span_word_t want;
            if (spans_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: span with nothing due: %s", $realtime, show(got));
                end
                return;
            end
            want = spans_due.pop_front();
            spans_seen++;
            if (got.x !== want.x || got.y !== want.y || got.len !== want.len ||
                got.red !== want.red || got.green !== want.green ||
                got.blue !== want.blue || got.alpha !== want.alpha ||
                got.last !== want.last || got.herr !== want.herr)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%0t: span mismatch", $realtime);
                    $display("    expected %s", show(want));
                    $display("    actual   %s", show(got));
                end
            end
        endfunction
    endclass

    logic clk = 1'b0;
    logic rst_n;

    srsd_item_if item_ch ();
    srsd_span_if span_ch ();
    srsd_cfg_if  cfg_ch ();

    sprite_rle_span_decoder_top u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .item  (item_ch),
        .span  (span_ch),
        .cfg   (cfg_ch)
    );

    span_scoreboard sb;
    bit             pal_written [256];
    int             tx_idle_pct;
    int             rx_idle_pct;
    bit             hold_req;
    int             words_sent;
    int             palette_writes;
    int             reg_writes;

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    initial
    begin
        #2_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

    // receiver: random back-pressure plus one long hold when asked
    initial
    begin
        bit seen_req;
        int hold_left;
        seen_req = 1'b0;
        hold_left = 0;
        span_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                span_ch.ready <= 1'b0;
            end
            else if (hold_req != seen_req)
            begin
                seen_req = hold_req;
                hold_left = HOLD_CYCLES;
                span_ch.ready <= 1'b0;
            end
            else
            begin
                span_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && span_ch.valid && span_ch.ready)
        begin
            sb.check_span({span_ch.span_x, span_ch.span_y, span_ch.span_length,
                           span_ch.red, span_ch.green, span_ch.blue, span_ch.alpha,
                           span_ch.last, span_ch.header_error});
        end
    end

    task automatic send_item(logic op, logic [7:0] code, logic [7:0] idx,
                             logic [7:0] r, logic [7:0] g, logic [7:0] b);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            item_ch.valid <= 1'b0;
            @(posedge clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.op <= op;
        item_ch.code_byte <= code;
        item_ch.pal_index <= idx;
        item_ch.pal_red <= r;
        item_ch.pal_green <= g;
        item_ch.pal_blue <= b;
        @(posedge clk);
        while (!item_ch.ready)
        begin
            @(posedge clk);
        end
        sb.note_item(op, code, idx, r, g, b);
        words_sent++;
    endtask

    task automatic send_palette(logic [7:0] idx, logic [7:0] r, logic [7:0] g,
                                logic [7:0] b);
        send_item(OP_PALETTE, 8'($urandom), idx, r, g, b);
        pal_written[idx] = 1'b1;
        palette_writes++;
    endtask

    function automatic logic [7:0] pick_colour();
        int c;
        do
        begin
            c = $urandom_range(255);
        end
        while (!pal_written[c]);
        return 8'(c);
    endfunction

    // bytes landing in a colour slot are steered onto loaded palette entries
    task automatic send_shape(logic [7:0] code);
        logic [7:0] b;
        if (sb.image_over())
        begin
            return;
        end
        b = code;
        if (sb.wants_colour() && !pal_written[b])
        begin
            b = pick_colour();
        end
        send_item(OP_SHAPE, b, 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
    endtask

    task automatic write_reg(logic [2:0] idx, int v);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data <= 11'(v);
        @(posedge clk);
        while (!cfg_ch.ready)
        begin
            @(posedge clk);
        end
        sb.write_reg(idx, 11'(v));
        reg_writes++;
    endtask

    task automatic wait_idle();
        item_ch.valid <= 1'b0;
        while (sb.pending() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic program_regs(int w, int h, int c0, int r0, int c1, int r1, int d);
        wait_idle();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        write_reg(REG_FIRST_COLUMN, c0);
        write_reg(REG_FIRST_ROW, r0);
        write_reg(REG_LAST_COLUMN, c1);
        write_reg(REG_LAST_ROW, r1);
        write_reg(REG_DEBUG_MODE, d);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic random_setup();
        int kind, w, h, c0, r0, c1, r1;
        kind = $urandom_range(11);
        w = $urandom_range(1, 48);
        h = $urandom_range(1, 24);
        if (kind == 0)
        begin
            w = MAX_DIM;
            h = MAX_DIM;
        end
        else if (kind == 1)
        begin
            w = 1;
            h = 1;
        end
        else if (kind == 2)
        begin
            w = $urandom_range(1, MAX_DIM);
            h = $urandom_range(1, MAX_DIM);
        end
        c0 = $urandom_range(0, w);
        c1 = $urandom_range(0, w);
        r0 = $urandom_range(0, h);
        r1 = $urandom_range(r0, h);
        if (kind == 3)
        begin
            // header outside the image, small sizes so w+1 stays in range
            case ($urandom_range(3))
                0: c0 = $urandom_range(w + 1, MAX_DIM);
                1: c1 = $urandom_range(w + 1, MAX_DIM);
                2: r0 = $urandom_range(h + 1, MAX_DIM);
                default: r1 = $urandom_range(h + 1, MAX_DIM);
            endcase
        end
        else if (kind == 4)
        begin
            r1 = $urandom_range(0, r0);
        end
        program_regs(w, h, c0, r0, c1, r1, $urandom_range(1));
    endtask

    task automatic send_token();
        int pick, n;
        pick = $urandom_range(99);
        if (pick < 8)
        begin
            send_palette(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        end
        else if (pick < 18)
        begin
            send_shape(8'($urandom));
        end
        else if (pick < 33)
        begin
            send_shape(CODE_ROW_END);
        end
        else if (pick < 53)
        begin
            send_shape(CODE_SKIP);
            send_shape(8'($urandom));
        end
        else if (pick < 78)
        begin
            n = $urandom_range(1, 127);
            send_shape(8'(2 * n));
            send_shape(pick_colour());
        end
        else
        begin
            n = ($urandom_range(19) == 0) ? $urandom_range(1, 127) : $urandom_range(1, 4);
            send_shape(8'(2 * n + 1));
            repeat (n) send_shape(pick_colour());
        end
    endtask

    task automatic run_random(int budget);
        int start, seg, seg_start;
        start = words_sent;
        while (words_sent - start < budget)
        begin
            random_setup();
            seg = $urandom_range(15, 60);
            seg_start = words_sent;
            while (words_sent - seg_start < seg && !sb.image_over())
            begin
                send_token();
            end
        end
    endtask

    initial
    begin
        int guard;
        sb = new();
        rst_n = 1'b0;
        item_ch.valid = 1'b0;
        item_ch.op = OP_SHAPE;
        item_ch.code_byte = '0;
        item_ch.pal_index = '0;
        item_ch.pal_red = '0;
        item_ch.pal_green = '0;
        item_ch.pal_blue = '0;
        cfg_ch.valid = 1'b0;
        cfg_ch.index = REG_IMAGE_WIDTH;
        cfg_ch.data = '0;
        hold_req = 1'b0;
        tx_idle_pct = 11;
        rx_idle_pct = 81;
        words_sent = 0;
        palette_writes = 0;
        reg_writes = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // full width row, all command kinds, last row end, then an ignored byte
        program_regs(MAX_DIM, 3, 0, 0, MAX_DIM, 2, 0);
        send_palette(8'h00, 8'h00, 8'h00, 8'h00);
        send_palette(8'hFF, 8'hFF, 8'hFF, 8'hFF);
        send_palette(8'hA5, 8'h5A, 8'hC3, 8'h3C);
        send_shape(CODE_ROW_END);
        send_shape(CODE_SKIP);
        send_shape(8'hFF);
        send_shape(8'hFE);
        send_shape(8'hFF);
        send_shape(8'h02);
        send_shape(8'h00);
        send_shape(8'h03);
        send_shape(8'hA5);
        send_shape(8'h07);
        send_shape(8'h00);
        send_shape(8'hFF);
        send_shape(8'hA5);
        send_shape(CODE_ROW_END);
        send_shape(CODE_ROW_END);
        send_item(OP_SHAPE, CODE_ROW_END, 8'h00, 8'h00, 8'h00, 8'h00);

        // start column past the image width
        program_regs(4, 4, 5, 0, 0, 0, 1);
        send_shape(8'h42);

        // debug colours, bottom rows, row beyond the image
        program_regs(16, MAX_DIM, 3, MAX_DIM - 1, 16, MAX_DIM, 1);
        send_shape(CODE_SKIP);
        send_shape(8'd10);
        send_shape(CODE_ROW_END);
        send_shape(CODE_ROW_END);

        run_random(230);

        wait_idle();
        tx_idle_pct = 81;
        rx_idle_pct <= 11;
        run_random(230);

        // no idling; a long receiver hold while a big image streams skips
        wait_idle();
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        program_regs(MAX_DIM, MAX_DIM, 0, 0, MAX_DIM, MAX_DIM, 0);
        hold_req <= 1'b1;
        repeat (30)
        begin
            send_shape(CODE_SKIP);
            send_shape(8'($urandom_range(1, 40)));
        end
        run_random(180);

        item_ch.valid <= 1'b0;
        guard = 0;
        while (sb.pending() != 0 && guard < DRAIN_LIMIT)
        begin
            @(posedge clk);
            guard++;
        end
        repeat (16) @(posedge clk);

        $display("covered %0d input words (%0d palette loads), %0d register writes",
                 words_sent, palette_writes, reg_writes);
        $display("checked %0d spans: %0d image ends, %0d header errors, %0d failures",
                 sb.spans_seen, sb.image_ends, sb.header_errors, sb.failures());
        if (sb.failures() == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/core/srsd_pkg.sv
rtl/core/srsd_if.sv
rtl/core/srsd_palette.sv
rtl/core/srsd_decode.sv
rtl/core/sprite_rle_span_decoder_top.sv
sim/sprite_rle_span_decoder_top_tb.sv
